@@ rtl/priority_event_queue_defines.svh @@
// ----------------------------------------------------------------------------
// Priority event queue assertion macros
// Shared checks for the queue RTL, clocked on clk; PEVQ_ASSERT skips reset.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_EVENT_QUEUE_DEFINES_SVH
`define PRIORITY_EVENT_QUEUE_DEFINES_SVH

// Check an implication on every rising clock edge outside reset.
`define PEVQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define PEVQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/pevq_pkg.sv @@
// ----------------------------------------------------------------------------
// Priority event queue package
// Sizes, operation and status codes, and the word and slot types.
// ----------------------------------------------------------------------------
`default_nettype none

package pevq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 5;

    localparam logic [1:0] KIND_POST   = 2'd0;
    localparam logic [1:0] KIND_TAKE   = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_NOMATCH = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  receiver;
        logic [6:0]  sender;
        logic [7:0]  ev_type;
        logic [7:0]  ev_id;
        logic [1:0]  priority_req;
        logic [31:0] payload;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [6:0]       out_receiver;
        logic [6:0]       out_sender;
        logic [7:0]       out_type;
        logic [7:0]       out_id;
        logic [1:0]       out_priority;
        logic [31:0]      out_payload;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

    // One stored event, 64 bits.
    typedef struct packed {
        logic [6:0]  receiver;
        logic [6:0]  sender;
        logic [7:0]  ev_type;
        logic [7:0]  ev_id;
        logic [1:0]  prio;
        logic [31:0] payload;
    } slot_t;

    typedef struct packed {
        logic later;
        logic match;
    } cmp_t;

endpackage

`default_nettype wire

@@ rtl/pevq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pevq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/pevq_cmp.sv @@
// ----------------------------------------------------------------------------
// Priority event queue compare unit
// Compares one stored event against the key of the operation in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module pevq_cmp (
    input  wire pevq_pkg::slot_t    entry,
    input  wire logic [1:0]         prio,
    input  wire logic [6:0]         receiver,
    input  wire logic [7:0]         ev_id,
    output pevq_pkg::cmp_t          result
);

    import pevq_pkg::*;

    always_comb
    begin
        // A new event goes behind every entry that is not strictly less urgent.
        result.later = (entry.prio > prio);
        result.match = (entry.receiver == receiver) && (entry.ev_id == ev_id);
    end

endmodule

`default_nettype wire

@@ rtl/priority_event_queue.sv @@
// ----------------------------------------------------------------------------
// Priority event queue
// Bounded event queue kept ordered by priority, stable among equals.
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_stall, req) carries one operation word:
// post, take head, or cancel by receiver and event id. The response channel
// (rsp_valid, rsp_stall, rsp) returns exactly one word per request, with a
// status, the event taken or cancelled, and the occupancy afterwards.
// Events live in a 16-entry RAM with one registered read port; a small
// sequencer walks it one entry at a time through a shared compare unit.
// A post walks from the tail, moving each less urgent entry one slot toward
// the tail, and writes the event into the slot left free. A take or cancel
// walks every queued entry from the head and closes the gap behind the one
// removed. Full, empty and unused-kind cases answer without a walk. The
// response word appears in the same cycle that req_stall drops. req_stall
// stays high while an operation is in progress. A finished word waits in
// the response register while the receiver stalls; the next request is
// still taken and worked on, and it waits to finish until that register is
// free. Reset empties the queue at once and drops any pending response.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_event_queue_defines.svh"

module priority_event_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire pevq_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output pevq_pkg::rsp_t       rsp
);

    import pevq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EV   = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       state_reg,  state_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [IDX_W-1:0] idx_reg,    idx_next;
    logic             found_reg,  found_next;
    logic [1:0]       status_reg, status_next;
    req_t             item_reg,   item_next;
    slot_t            evt_reg,    evt_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg,    rsp_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    slot_t            ram_wdata;
    slot_t            ram_rdata;
    cmp_t             cmp;
    slot_t            new_slot;
    logic             rsp_free;
    logic             scan_last;
    logic             hit;

    pevq_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    pevq_cmp u_cmp (
        .entry    (ram_rdata),
        .prio     (item_reg.priority_req),
        .receiver (item_reg.receiver),
        .ev_id    (item_reg.ev_id),
        .result   (cmp)
    );

    always_comb
    begin
        new_slot.receiver = item_reg.receiver;
        new_slot.sender   = item_reg.sender;
        new_slot.ev_type  = item_reg.ev_type;
        new_slot.ev_id    = item_reg.ev_id;
        new_slot.prio     = item_reg.priority_req;
        new_slot.payload  = item_reg.payload;
    end

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign scan_last = (CNT_W'(idx_reg) == CNT_W'(count_reg - CNT_W'(1)));
    assign hit       = (item_reg.kind == KIND_TAKE) ? (idx_reg == '0) : cmp.match;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        item_next      = item_reg;
        evt_next       = evt_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = ram_rdata;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next   = req;
                    evt_next    = '0;
                    found_next  = 1'b0;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    case (req.kind)
                        KIND_POST:
                        begin
                            if (count_reg >= CNT_W'(QUEUE_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = S_WR;
                            end
                            else
                            begin
                                // Walk from the tail toward the head.
                                idx_next   = IDX_W'(count_reg - CNT_W'(1));
                                state_next = S_RD;
                            end
                        end
                        KIND_TAKE, KIND_CANCEL:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = (req.kind == KIND_TAKE) ? ST_EMPTY
                                                                      : ST_NOMATCH;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                state_next = S_EV;
            end

            S_EV:
            begin
                if (item_reg.kind == KIND_POST)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = IDX_W'(idx_reg + 1'b1);
                    if (cmp.later)
                    begin
                        // Less urgent entry moves one slot toward the tail.
                        ram_wdata = ram_rdata;
                        if (idx_reg == '0)
                        begin
                            state_next = S_WR;
                        end
                        else
                        begin
                            idx_next   = IDX_W'(idx_reg - 1'b1);
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        ram_wdata  = new_slot;
                        count_next = CNT_W'(count_reg + CNT_W'(1));
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    if (found_reg)
                    begin
                        // Close the gap left by the removed entry.
                        ram_we    = 1'b1;
                        ram_waddr = IDX_W'(idx_reg - 1'b1);
                        ram_wdata = ram_rdata;
                    end
                    else if (hit)
                    begin
                        evt_next   = ram_rdata;
                        found_next = 1'b1;
                    end

                    if (scan_last)
                    begin
                        if (found_reg || hit)
                        begin
                            count_next  = CNT_W'(count_reg - CNT_W'(1));
                            status_next = ST_OK;
                        end
                        else
                        begin
                            status_next = ST_NOMATCH;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = IDX_W'(idx_reg + 1'b1);
                        state_next = S_RD;
                    end
                end
            end

            S_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = new_slot;
                count_next = CNT_W'(count_reg + CNT_W'(1));
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.status       = status_reg;
                    rsp_next.out_receiver = evt_reg.receiver;
                    rsp_next.out_sender   = evt_reg.sender;
                    rsp_next.out_type     = evt_reg.ev_type;
                    rsp_next.out_id       = evt_reg.ev_id;
                    rsp_next.out_priority = evt_reg.prio;
                    rsp_next.out_payload  = evt_reg.payload;
                    rsp_next.occupancy    = OCC_W'(count_reg);
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        item_reg   <= item_next;
        evt_reg    <= evt_next;
        rsp_reg    <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `PEVQ_ASSERT(a_we_in_work, ram_we |-> (state_reg == S_EV || state_reg == S_WR), "RAM written outside a work state")
    `PEVQ_ASSERT(a_idle_count, (state_reg == S_IDLE) |=> $stable(count_reg), "Queue count changed while idle")
    `PEVQ_ASSERT(a_idx_in_range, (state_reg == S_EV) |-> (CNT_W'(idx_reg) < count_reg), "Scan index beyond queued events")
    `PEVQ_ASSERT(a_full_occ, (rsp_valid && rsp.status == ST_FULL) |-> (rsp.occupancy == OCC_W'(QUEUE_DEPTH)), "Full status with queue not full")
    `PEVQ_ASSERT_ALWAYS(a_count_max, !rst_n || (count_reg <= CNT_W'(QUEUE_DEPTH)), "Queue count above depth")

endmodule

`default_nettype wire

@@ tb/tb_priority_event_queue.sv @@
// ----------------------------------------------------------------------------
// Priority event queue testbench
// Posts, takes and cancels events through the request channel and checks
// every response word against a queue model kept ordered by priority. A short
// directed run covers the empty, full, no-match and unused-kind cases. Random
// bursts follow, each leaning toward filling or draining, under changing
// idle patterns on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_priority_event_queue;

    timeunit 1ns;
    timeprecision 1ps;

    import pevq_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         PHASE_OPS   = 610;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    req_t   pending_ops[$];
    rsp_t   due_responses[$];
    slot_t  model_events[$];
    logic [14:0] posted_keys[$];

    int send_idle_pct = 13;
    int recv_idle_pct = 82;
    int mismatches    = 0;
    int cycle_count   = 0;

    priority_event_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("priority_event_queue verification failed");
            $finish;
        end
    end

    function automatic req_t make_req(logic [1:0] kind, logic [6:0] rcv, logic [6:0] snd,
                                      logic [7:0] typ, logic [7:0] id, logic [1:0] pr,
                                      logic [31:0] data);
        req_t r;
        r.kind         = kind;
        r.receiver     = rcv;
        r.sender       = snd;
        r.ev_type      = typ;
        r.ev_id        = id;
        r.priority_req = pr;
        r.payload      = data;
        return r;
    endfunction

    function automatic void fill_event(inout rsp_t w, input slot_t e);
        w.out_receiver = e.receiver;
        w.out_sender   = e.sender;
        w.out_type     = e.ev_type;
        w.out_id       = e.ev_id;
        w.out_priority = e.prio;
        w.out_payload  = e.payload;
    endfunction

    // Applies one operation to the queue model and returns the response word.
    function automatic rsp_t apply_operation(req_t r);
        rsp_t  w;
        slot_t e;
        int    n;
        int    pos;
        w   = '0;
        n   = model_events.size();
        pos = n;
        case (r.kind)
            KIND_POST:
            begin
                if (n >= QUEUE_DEPTH)
                    w.status = ST_FULL;
                else
                begin
                    e.receiver = r.receiver;
                    e.sender   = r.sender;
                    e.ev_type  = r.ev_type;
                    e.ev_id    = r.ev_id;
                    e.prio     = r.priority_req;
                    e.payload  = r.payload;
                    // A new event goes behind all events of equal or higher urgency.
                    for (int i = 0; i < n; i++)
                        if (pos == n && model_events[i].prio > r.priority_req)
                            pos = i;
                    model_events.insert(pos, e);
                end
            end
            KIND_TAKE:
            begin
                if (n == 0)
                    w.status = ST_EMPTY;
                else
                    fill_event(w, model_events.pop_front());
            end
            KIND_CANCEL:
            begin
                for (int i = 0; i < n; i++)
                    if (pos == n && model_events[i].receiver == r.receiver
                            && model_events[i].ev_id == r.ev_id)
                        pos = i;
                if (pos == n)
                    w.status = ST_NOMATCH;
                else
                begin
                    fill_event(w, model_events[pos]);
                    model_events.delete(pos);
                end
            end
            default: ;
        endcase
        w.occupancy = OCC_W'(model_events.size());
        return w;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Random operations in bursts of twenty, each burst leaning toward filling
    // or draining the queue. Cancels mostly name a recently posted event.
    function automatic void add_random_ops(int total);
        req_t        r;
        int          post_pct;
        int          roll;
        logic [14:0] key;
        post_pct = 50;
        for (int i = 0; i < total; i++)
        begin
            if (i % 20 == 0)
            begin
                roll     = $urandom_range(2);
                post_pct = (roll == 0) ? 75 : (roll == 1) ? 45 : 25;
            end
            r = make_req(KIND_POST, 7'($urandom_range(127)), 7'($urandom_range(127)),
                         8'($urandom_range(255)), 8'($urandom_range(255)),
                         2'($urandom_range(3)), $urandom);
            if ($urandom_range(3) == 0)
            begin
                r.receiver = 7'($urandom_range(3));
                r.ev_id    = 8'($urandom_range(3));
            end
            roll = $urandom_range(99);
            if (roll < 3)
                r.kind = KIND_UNUSED;
            else if (roll < post_pct)
                r.kind = KIND_POST;
            else if (roll < post_pct + (100 - post_pct) / 2)
                r.kind = KIND_TAKE;
            else
            begin
                r.kind = KIND_CANCEL;
                if (posted_keys.size() > 0 && $urandom_range(3) != 0)
                begin
                    key = posted_keys[$urandom_range(posted_keys.size() - 1)];
                    {r.receiver, r.ev_id} = key;
                end
            end
            if (r.kind == KIND_POST)
            begin
                posted_keys.push_back({r.receiver, r.ev_id});
                if (posted_keys.size() > 32)
                    void'(posted_keys.pop_front());
            end
            pending_ops.push_back(r);
        end
    endfunction

    // Request driver: a word is held until accepted, then the model is updated.
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic go;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (req_valid)
                due_responses.push_back(apply_operation(req));
            go = pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct;
            if (go)
            begin
                req       <= pending_ops.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Response monitor with random stalls.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        rsp_t want;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (due_responses.size() == 0)
                begin
                    $error("response word arrived with none outstanding");
                    mismatches++;
                end
                else
                begin
                    want = due_responses.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp.status));
                    check_field("out_receiver", 32'(want.out_receiver),
                                32'(rsp.out_receiver));
                    check_field("out_sender", 32'(want.out_sender), 32'(rsp.out_sender));
                    check_field("out_type", 32'(want.out_type), 32'(rsp.out_type));
                    check_field("out_id", 32'(want.out_id), 32'(rsp.out_id));
                    check_field("out_priority", 32'(want.out_priority),
                                32'(rsp.out_priority));
                    check_field("out_payload", want.out_payload, rsp.out_payload);
                    check_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
                end
            end
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic drain();
        while (pending_ops.size() != 0 || req_valid || due_responses.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Empty queue cases and the unused kind with every bit set.
        pending_ops.push_back(make_req(KIND_TAKE, 7'd0, 7'd0, 8'd0, 8'd0, 2'd0, 32'd0));
        pending_ops.push_back(make_req(KIND_CANCEL, 7'd5, 7'd0, 8'd0, 8'd9, 2'd0, 32'd0));
        pending_ops.push_back(make_req(KIND_UNUSED, 7'd127, 7'd127, 8'd255, 8'd255, 2'd3,
                                       32'hffff_ffff));
        pending_ops.push_back(make_req(KIND_POST, 7'd0, 7'd0, 8'd0, 8'd0, 2'd0, 32'd0));
        pending_ops.push_back(make_req(KIND_POST, 7'd127, 7'd127, 8'd255, 8'd255, 2'd3,
                                       32'hffff_ffff));
        // Fill past capacity with repeated priorities; the last post hits a full queue.
        for (int i = 0; i < 15; i++)
            pending_ops.push_back(make_req(KIND_POST, 7'(i), 7'(100 - i), 8'(8 * i),
                                           8'(i + 16), 2'((i * 3) % 4), $urandom));
        pending_ops.push_back(make_req(KIND_CANCEL, 7'd3, 7'd0, 8'd0, 8'd19, 2'd0, 32'd0));
        pending_ops.push_back(make_req(KIND_CANCEL, 7'd100, 7'd0, 8'd0, 8'd1, 2'd0, 32'd0));
        pending_ops.push_back(make_req(KIND_TAKE, 7'd0, 7'd0, 8'd0, 8'd0, 2'd0, 32'd0));
        pending_ops.push_back(make_req(KIND_UNUSED, 7'd0, 7'd0, 8'd0, 8'd0, 2'd0, 32'd0));

        add_random_ops(PHASE_OPS);
        drain();

        send_idle_pct = 82;
        recv_idle_pct = 13;
        add_random_ops(PHASE_OPS);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_ops(PHASE_OPS);
        drain();

        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("priority_event_queue verification clean");
        else
            $display("priority_event_queue verification failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/pevq_pkg.sv
rtl/pevq_ram.sv
rtl/pevq_cmp.sv
rtl/priority_event_queue.sv
tb/tb_priority_event_queue.sv
